>>> rtl/core/lsbp_pkg.sv
// ----------------------------------------------------------------------------
// LSB-first bit packer package
// Shared types and constants for the bit packer channels and datapath.
// ----------------------------------------------------------------------------
package lsbp_pkg;

    // Upper bound on the buffer capacity; larger register values are clamped.
    localparam int MAX_BUFFER_BYTES = 65536;

    localparam int WORD_W    = 64;
    localparam int FIELD_W   = 32;
    localparam int FILL_W    = 6;
    localparam int BITS_W    = 20;
    localparam int SLOT_W    = 14;
    localparam int INDEX_W   = 13;
    localparam int BUFBYTE_W = 17;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_ALIGN = 2'd2,
        ACT_FLUSH = 2'd3
    } action_t;

    typedef struct packed {
        action_t             action;
        logic [FIELD_W-1:0]  field_value;
        logic [5:0]          field_width;
    } cmd_t;

    typedef struct packed {
        logic                ok;
        logic                error;
        logic                word_valid;
        logic [WORD_W-1:0]   out_word;
        logic [INDEX_W-1:0]  out_word_index;
        logic [BITS_W-1:0]   total_bits;
    } rsp_t;

    typedef struct packed {
        logic [WORD_W-1:0]   scratch_word;
        logic [FILL_W-1:0]   scratch_fill;
        logic [BITS_W-1:0]   bits_so_far;
        logic [SLOT_W-1:0]   next_word_slot;
        logic                sticky_error;
    } state_t;

endpackage

>>> rtl/core/lsbp_if.sv
// ----------------------------------------------------------------------------
// LSB-first bit packer channels
// Valid/ready interfaces for the command and response channels.
// ----------------------------------------------------------------------------
interface lsbp_cmd_if;
    import lsbp_pkg::*;

    logic valid;
    logic ready;
    cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lsbp_rsp_if;
    import lsbp_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/lsbp_step.sv
// ----------------------------------------------------------------------------
// LSB-first bit packer step logic
// Computes the next packer state and the response word for one command.
// ----------------------------------------------------------------------------
module lsbp_step (
    input  lsbp_pkg::state_t                  st,
    input  lsbp_pkg::cmd_t                    cmd,
    input  logic [lsbp_pkg::BUFBYTE_W-1:0]    buffer_bytes,
    output lsbp_pkg::state_t                  st_next,
    output lsbp_pkg::rsp_t                    rsp
);
    import lsbp_pkg::*;

    logic [BUFBYTE_W-1:0]   cap_bytes;
    logic [BITS_W-1:0]      cap_bits;
    logic                   wr_en;
    logic [FIELD_W-1:0]     wr_value;
    logic [5:0]             wr_width;
    logic [FIELD_W-1:0]     masked;
    logic [WORD_W+FIELD_W-1:0] placed;
    logic [WORD_W-1:0]      merged;
    logic [FILL_W:0]        fill_after;
    logic [BITS_W:0]        bits_after;
    logic                   bad_width;
    logic                   over_cap;
    logic [2:0]             rem;

    always_comb
    begin
        if (32'(buffer_bytes) > MAX_BUFFER_BYTES)
        begin
            cap_bytes = MAX_BUFFER_BYTES[BUFBYTE_W-1:0];
        end
        else
        begin
            cap_bytes = buffer_bytes;
        end
    end

    assign cap_bits = {cap_bytes, 3'b000};
    assign rem      = st.bits_so_far[2:0];

    // Write path shared by field writes and alignment padding.
    assign masked     = wr_value & ~({FIELD_W{1'b1}} << wr_width);
    assign placed     = {{WORD_W{1'b0}}, masked} << st.scratch_fill;
    assign merged     = st.scratch_word | placed[WORD_W-1:0];
    assign fill_after = {1'b0, st.scratch_fill} + {1'b0, wr_width};
    assign bits_after = {1'b0, st.bits_so_far} + {{(BITS_W-5){1'b0}}, wr_width};
    assign bad_width  = (wr_width == 6'd0) || (wr_width > 6'd32);
    assign over_cap   = bits_after > {1'b0, cap_bits};

    always_comb
    begin
        st_next  = st;
        rsp      = '0;
        wr_en    = 1'b0;
        wr_value = '0;
        wr_width = '0;

        unique case (cmd.action)
            ACT_START:
            begin
                st_next = '0;
                rsp.ok  = 1'b1;
            end
            ACT_WRITE:
            begin
                if (!st.sticky_error)
                begin
                    wr_en    = 1'b1;
                    wr_value = cmd.field_value;
                    wr_width = cmd.field_width;
                end
            end
            ACT_ALIGN:
            begin
                if (!st.sticky_error)
                begin
                    if (rem != 3'd0)
                    begin
                        wr_en    = 1'b1;
                        wr_width = {2'b00, 4'(4'd8 - {1'b0, rem})};
                    end
                    else
                    begin
                        rsp.ok = 1'b1;
                    end
                end
            end
            ACT_FLUSH:
            begin
                if (!st.sticky_error)
                begin
                    if (st.scratch_fill != '0)
                    begin
                        rsp.word_valid         = 1'b1;
                        rsp.out_word           = st.scratch_word;
                        rsp.out_word_index     = st.next_word_slot[INDEX_W-1:0];
                        st_next.next_word_slot = st.next_word_slot + SLOT_W'(1);
                        st_next.scratch_word   = '0;
                        st_next.scratch_fill   = '0;
                    end
                    rsp.ok = 1'b1;
                end
            end
            default:
            begin
                rsp.ok = 1'b0;
            end
        endcase

        if (wr_en)
        begin
            if (bad_width || over_cap)
            begin
                st_next.sticky_error = 1'b1;
            end
            else
            begin
                // A full word leaves with its slot; the spilled bits start the next one.
                if (fill_after[FILL_W])
                begin
                    rsp.word_valid         = 1'b1;
                    rsp.out_word           = merged;
                    rsp.out_word_index     = st.next_word_slot[INDEX_W-1:0];
                    st_next.next_word_slot = st.next_word_slot + SLOT_W'(1);
                    st_next.scratch_word   = {{(WORD_W-FIELD_W){1'b0}},
                                              placed[WORD_W+FIELD_W-1:WORD_W]};
                end
                else
                begin
                    st_next.scratch_word = merged;
                end
                st_next.scratch_fill = fill_after[FILL_W-1:0];
                st_next.bits_so_far  = bits_after[BITS_W-1:0];
                rsp.ok               = 1'b1;
            end
        end

        rsp.error      = st_next.sticky_error;
        rsp.total_bits = st_next.bits_so_far;
    end

endmodule

>>> rtl/core/lsb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// LSB-first bit packer
// Packs 1 to 32 bit fields into 64-bit words, least significant bit first.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the cmd channel (start, write field, align, flush) and
// each accepted command produces exactly one response word on the rsp
// channel, carrying ok, the sticky error flag, the running bit count and,
// when a 64-bit word completed or was flushed, that word and its buffer index.
// The capacity register, written through cfg_we/cfg_wdata, holds the buffer
// size in bytes and resets to 4096; the user must write it only while the
// block is idle, which the block does not enforce. The response is registered
// and valid in the cycle after its command is accepted. While responses are
// taken, a command can be accepted every cycle: state and response register
// update at the accepting edge. On a stall the held response stays put and
// cmd.ready drops until taken, so none is lost. Reset clears state and valid.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer (
    input  logic                              clk,
    input  logic                              rst_n,
    lsbp_cmd_if.sink                          cmd,
    lsbp_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [lsbp_pkg::BUFBYTE_W-1:0]    cfg_wdata
);
    import lsbp_pkg::*;

    localparam logic [BUFBYTE_W-1:0] BUF_BYTES_RESET = BUFBYTE_W'(4096);

    state_t               state_reg;
    state_t               state_next;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;
    logic                 rsp_valid_reg;
    logic [BUFBYTE_W-1:0] buf_bytes_reg;
    logic                 cmd_accept;

    lsbp_step u_step (
        .st           (state_reg),
        .cmd          (cmd.payload),
        .buffer_bytes (buf_bytes_reg),
        .st_next      (state_next),
        .rsp          (rsp_next)
    );

    assign cmd.ready   = !rsp_valid_reg || rsp.ready;
    assign cmd_accept  = cmd.valid && cmd.ready;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            buf_bytes_reg <= BUF_BYTES_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                buf_bytes_reg <= cfg_wdata;
            end
            if (cmd_accept)
            begin
                state_reg     <= state_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule
